// ----- sv/ilst_pkg.sv -----
// package for the indexed ordered list: request and status codes,
// field widths and the result beat struct shared by the sequencer and the top level
// no dependencies
package ilst_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int REQ_W     = 2;
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = REQ_W;
    localparam int M_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE_POS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE_VAL = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ       = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] list_count;
        logic [STATUS_W-1:0]  status;
        logic [DATA_W-1:0]    read_value;
    } res_t;

endpackage

// ----- sv/ilst_mem.sv -----
// entry store of the indexed ordered list: one write port, one read port,
// registered read data
// no package dependencies
module ilst_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ilst_ctrl.sv -----
// request sequencer of the indexed ordered list: decodes a request, walks the
// entry store to shift, scan or read, and holds the result until taken
// depends on ilst_pkg
module ilst_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ilst_pkg::REQ_W-1:0]    in_req,
    input  logic [ilst_pkg::POS_W-1:0]    in_pos,
    input  logic                          in_append,
    input  logic [ilst_pkg::DATA_W-1:0]   in_value,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ilst_pkg::res_t                res,
    output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  logic [VALUE_WIDTH-1:0]        mem_rdata,
    output logic                          mem_we,
    output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
    output logic [VALUE_WIDTH-1:0]        mem_wdata
);

    import ilst_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UP    = 3'd1;
    localparam logic [2:0] S_DN    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;
    localparam logic [2:0] S_RDCAP = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [REQ_W-1:0]       op_reg, op_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [DATA_W-1:0]      rd_reg, rd_next;
    logic [STATUS_W-1:0]    st_reg, st_next;

    logic [CMP_W-1:0]       pos_c, cnt_c, ins_c;
    logic [63:0]            val_wide, rdata_wide;
    logic [CNT_W-1:0]       idx_inc, idx_dec, cnt_last;

    assign pos_c      = CMP_W'(in_pos);
    assign cnt_c      = CMP_W'(cnt_reg);
    assign ins_c      = in_append ? cnt_c : pos_c;
    assign val_wide   = 64'(in_value);
    assign rdata_wide = 64'(mem_rdata);
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_dec    = idx_reg - 1'b1;
    assign cnt_last   = cnt_reg - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        chk_valid_next  = chk_valid_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        chk_idx_next    = chk_idx_reg;
        pend_addr_next  = pend_addr_reg;
        val_next        = val_reg;
        rd_next         = rd_reg;
        st_next         = st_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        mem_raddr       = idx_reg[AW-1:0];
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = pos_c[AW-1:0];
                if (in_valid)
                begin
                    val_next        = val_wide[VALUE_WIDTH-1:0];
                    rd_next         = '0;
                    st_next         = ST_OK;
                    op_next         = in_req;
                    pend_valid_next = 1'b0;
                    chk_valid_next  = 1'b0;
                    case (in_req)
                        REQ_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(CAPACITY))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_DONE;
                            end
                            else if (ins_c > cnt_c)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                p_next = CNT_W'(ins_c);
                                if (ins_c == cnt_c)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    idx_next   = cnt_last;
                                    state_next = S_UP;
                                end
                            end
                        end
                        REQ_REMOVE_POS:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                p_next = CNT_W'(pos_c);
                                if (CNT_W'(pos_c) == cnt_last)
                                begin
                                    cnt_next   = cnt_last;
                                    state_next = S_DONE;
                                end
                                else
                                begin
                                    idx_next   = CNT_W'(pos_c) + 1'b1;
                                    state_next = S_DN;
                                end
                            end
                        end
                        REQ_REMOVE_VAL:
                        begin
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_ABSENT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                st_next    = ST_RANGE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDCAP;
                            end
                        end
                    endcase
                end
            end
            // walk down from the last entry, each one moves up by one
            S_UP:
            begin
                mem_we          = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = idx_inc[AW-1:0];
                if (idx_reg == p_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_dec;
                end
            end
            // walk up from the gap, each entry moves down by one
            S_DN:
            begin
                mem_we          = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = idx_dec[AW-1:0];
                if (idx_reg == cnt_last)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            S_DRAIN:
            begin
                mem_we          = 1'b1;
                pend_valid_next = 1'b0;
                if (op_reg == REQ_INSERT)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next   = cnt_last;
                    state_next = S_DONE;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg[AW-1:0];
                mem_wdata  = val_reg;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_DONE;
            end
            // read one entry a cycle, compare the one read the cycle before
            S_SCAN:
            begin
                chk_valid_next = 1'b1;
                chk_idx_next   = idx_reg;
                idx_next       = idx_inc;
                if (chk_valid_reg)
                begin
                    if (mem_rdata == val_reg)
                    begin
                        chk_valid_next = 1'b0;
                        p_next         = chk_idx_reg;
                        if (chk_idx_reg == cnt_last)
                        begin
                            cnt_next   = cnt_last;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next        = chk_idx_reg + 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = S_DN;
                        end
                    end
                    else if (chk_idx_reg == cnt_last)
                    begin
                        chk_valid_next = 1'b0;
                        st_next        = ST_ABSENT;
                        state_next     = S_DONE;
                    end
                end
            end
            S_RDCAP:
            begin
                rd_next    = rdata_wide[DATA_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.read_value = rd_reg;
    assign res.status     = st_reg;
    assign res.list_count = CNT_OUT_W'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            chk_valid_reg  <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        p_reg         <= p_next;
        chk_idx_reg   <= chk_idx_next;
        pend_addr_reg <= pend_addr_next;
        val_reg       <= val_next;
        rd_reg        <= rd_next;
        st_reg        <= st_next;
    end

endmodule

// ----- sv/indexed_ordered_list.sv -----
// top level of the indexed ordered list: stream ports, output register,
// request sequencer and entry store
// depends on ilst_pkg, ilst_ctrl, ilst_mem
//
// usage
// s channel: one request beat per item; s_tuser carries the request kind,
// s_tdata the position, the append flag and the value
// m channel: exactly one result beat per request: read value, status and
// the entry count after the request
// one request is in work at a time; s_tready is high while the sequencer
// waits for a request, also while an earlier result still sits in the
// output register
// a read captures the entry, then reports it; a rejected request reports at once
// an insert at position p below count moves the entries from p up by one, then writes
// the value; an append writes it directly; a removal at p below count - 1 moves the
// entries above p down by one; a removal of the last entry only lowers the count; a
// removal by value scans for the value, then moves the entries above it down by one
// the sequencer is ready again in the cycle m_tvalid rises; the longest item is a
// removal by value from a full list: a scan, then one entry shift per cycle
// reset empties the list at once (count to zero); the store needs no clearing
// if m_tready stays low the result waits in the output register, the next
// result waits in the sequencer, and no further request is taken
module indexed_ordered_list #(
    parameter int CAPACITY    = ilst_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ilst_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // position[4:0], append_at_end[5], value[37:6], zero pad[39:38]
    input  logic [ilst_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[1:0]
    input  logic [ilst_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_value[31:0], status[33:32], list_count[38:34], zero pad[39]
    output logic [ilst_pkg::M_TDATA_W-1:0] m_tdata
);

    import ilst_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic                   res_valid, res_ready;
    res_t                   res;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_rdata, mem_wdata;
    logic                   mem_we;

    logic                   out_valid_reg, out_valid_next;
    res_t                   out_reg, out_next;

    ilst_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser[REQ_W-1:0]),
        .in_pos    (s_tdata[4:0]),
        .in_append (s_tdata[5]),
        .in_value  (s_tdata[37:6]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    ilst_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_mem (
        .clk   (clk),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    // the sequencer never takes a request while it holds a result
    a_ready_vs_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !res_valid)
        else $error("request taken while a result is pending");

    // a pending result stays until the output register takes it
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("pending result dropped");

    // a full list reports a count of CAPACITY
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status == ST_FULL |-> out_reg.list_count == CNT_OUT_W'(CAPACITY))
        else $error("full status with wrong count");

    // read value is zero on any failed request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_reg.status != ST_OK |-> out_reg.read_value == '0)
        else $error("nonzero read value on failed request");

endmodule
